### rtl/bfa_pkg.sv
package bfa_pkg;

  // heap geometry
  localparam int HEAP_MAX_BYTES = 65536;
  localparam int ALIGN_BYTES    = 8;
  localparam int HEADER_BYTES   = 16;
  localparam int GRANULES       = HEAP_MAX_BYTES / ALIGN_BYTES;
  localparam int GIDX_W         = $clog2(GRANULES);
  localparam int LINK_W         = GIDX_W + 1;
  localparam int ALIGN_SH       = $clog2(ALIGN_BYTES);
  localparam int OFF_W          = GIDX_W + ALIGN_SH;
  localparam int SIZE_W         = $clog2(HEAP_MAX_BYTES + 1);
  localparam int MIN_NEED       = ALIGN_BYTES * 2;
  localparam int MIN_HEAP       = ALIGN_BYTES * 3;
  localparam int MIN_SPLIT      = HEADER_BYTES * 3;

  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(GRANULES);

  // configuration register indexes
  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_HEAP_BYTES = 1'b1;

  typedef enum logic [1:0] {
    ACT_INIT    = 2'd0,
    ACT_ALLOC   = 2'd1,
    ACT_FREE    = 2'd2,
    ACT_REALLOC = 2'd3
  } act_e;

  // one block header
  typedef struct packed {
    logic [LINK_W-1:0] next;
    logic [LINK_W-1:0] prev;
    logic              used;
    logic [SIZE_W-1:0] size;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  // datapath steps
  typedef enum logic [5:0] {
    OP_IDLE,
    OP_DISP,
    OP_INIT,
    OP_RD_X,
    OP_LK,
    OP_SET_OK,
    OP_SP_X,
    OP_OK_X,
    OP_TK_INIT,
    OP_RG_TOOK,
    OP_AL_END,
    OP_T_RD,
    OP_T_CHK,
    OP_T_END,
    OP_T_UL,
    OP_RD_BEST,
    OP_WR_USED,
    OP_SP_RD,
    OP_SP_CHK,
    OP_PU_WR,
    OP_RD_HEAD,
    OP_HEAD_PREV,
    OP_SET_HEAD,
    OP_UL_RD,
    OP_UL_GET,
    OP_UL_P,
    OP_UL_PWR,
    OP_UL_N,
    OP_UL_NWR,
    OP_REL,
    OP_AB_RF,
    OP_AB_CHK,
    OP_AB_MRGW,
    OP_NOP,
    OP_DONE
  } op_e;

  typedef struct packed {
    op_e  op;
    logic take_in;
  } cmd_t;

  typedef struct packed {
    act_e act;
    logic ready;
    logic addr_zero;
    logic req_zero;
    logic addr_ok;
    logic rd_used;
    logic cur_valid;
    logic found;
    logic fits_x;
    logic split_ok;
    logic head_valid;
    logic p_valid;
    logic n_valid;
    logic rf_in;
    logic out_free;
  } stat_t;

  function automatic logic link_ok(logic [LINK_W-1:0] l);
    return l < LINK_W'(GRANULES);
  endfunction

endpackage

### rtl/best_fit_free_list_allocator_unit.sv
// Best-fit allocator for the block headers of one heap. Each input transfer is one
// request (init, allocate, free, reallocate) and gives exactly one result transfer.
// All headers live in one header RAM with a registered read, and each sequencer step
// makes at most one header read and one header write, so the time per request
// follows the number of header accesses: init writes one header, allocate walks
// the whole free list and then splits and unlinks the best fit if one is found, free
// pushes the block and merges each free right neighbour, and reallocate is made
// of merge, split, allocate and free parts. The header RAM needs no clearing pass;
// configure heap_base and heap_bytes, then send init.
module best_fit_free_list_allocator_unit import bfa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // block_address, request_bytes
  input  logic [1:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // result_address, copy_bytes, zero fill
  output logic [1:0]  m_axis_tuser,   // ok, copy_needed
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  cmd_t  cmd;
  stat_t stat;

  bfa_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  bfa_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

endmodule

### rtl/bfa_ram.sv
module bfa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/bfa_dp.sv
module bfa_dp import bfa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  input  logic [63:0] s_axis_tdata,   // block_address, request_bytes
  input  logic [1:0]  s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // result_address, copy_bytes, zero fill
  output logic [1:0]  m_axis_tuser,   // ok, copy_needed
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  // control state
  logic [31:0]       cfg_base_q;
  logic [SIZE_W-1:0] cfg_bytes_q;
  logic              ready_q;
  logic [LINK_W-1:0] head_q;
  logic              out_valid_q;

  // working registers
  act_e              act_q;
  logic [31:0]       addr_q;
  logic [31:0]       req_q;
  logic [32:0]       need_q;
  logic [32:0]       lo_q;
  logic [SIZE_W-1:0] end_q;
  logic [GIDX_W-1:0] x_q, best_q, nb_q, sp_q, pu_q, ul_q;
  logic [SIZE_W-1:0] xsz_q, bsz_q, nbsz_q, pusz_q;
  logic [LINK_W-1:0] cur_q, p_q, n_q;
  logic              found_q;
  logic              res_ok_q, res_copy_q;
  logic [31:0]       res_addr_q;
  logic [SIZE_W-1:0] res_cb_q;
  logic              out_ok_q, out_copy_q;
  logic [31:0]       out_addr_q;
  logic [SIZE_W-1:0] out_cb_q;

  // header memory port
  logic              we;
  logic [GIDX_W-1:0] waddr, raddr;
  hdr_t              wdata, rdata;

  bfa_ram #(.Width(HDR_W), .Depth(GRANULES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  function automatic logic [32:0] need_of(logic [31:0] r);
    if (r <= 32'(MIN_NEED)) begin
      return 33'(MIN_NEED);
    end
    return ({1'b0, r} + 33'(ALIGN_BYTES - 1)) & ~33'(ALIGN_BYTES - 1);
  endfunction

  function automatic logic [31:0] payload(logic [32:0] lo, logic [GIDX_W-1:0] g);
    return lo[31:0] + 32'(OFF_W'(g) << ALIGN_SH);
  endfunction

  // init checks
  logic [32:0] heap_top;
  logic        cfg_ok;
  assign heap_top = {1'b0, cfg_base_q} + 33'(cfg_bytes_q);
  assign cfg_ok = !(cfg_bytes_q < SIZE_W'(MIN_HEAP) || cfg_bytes_q <= SIZE_W'(HEADER_BYTES) ||
                    cfg_bytes_q > SIZE_W'(HEAP_MAX_BYTES) ||
                    (heap_top[32] && heap_top[31:0] != 32'd0));

  // payload address to granule
  logic [32:0]       off;
  logic              addr_ok;
  logic [GIDX_W-1:0] addr_idx;
  assign off      = {1'b0, addr_q} - lo_q;
  assign addr_ok  = ({1'b0, addr_q} >= lo_q) && (off < 33'(end_q)) &&
                    (off[ALIGN_SH-1:0] == '0);
  assign addr_idx = off[OFF_W-1:ALIGN_SH];

  // split of the block just read
  logic [SIZE_W-1:0] sp_rem;
  logic [OFF_W+1:0]  cut_off;
  logic              split_ok;
  assign sp_rem   = rdata.size - need_q[SIZE_W-1:0];
  assign cut_off  = (OFF_W+2)'(OFF_W'(sp_q) << ALIGN_SH) + (OFF_W+2)'(HEADER_BYTES) +
                    (OFF_W+2)'(need_q[SIZE_W-1:0]);
  assign split_ok = ({16'd0, rdata.size} >= need_q) && (sp_rem >= SIZE_W'(MIN_SPLIT)) &&
                    (cut_off < (OFF_W+2)'(end_q));

  // right neighbour of x
  logic [OFF_W+1:0]  right_off;
  logic [SIZE_W-1:0] merged;
  assign right_off = (OFF_W+2)'(OFF_W'(x_q) << ALIGN_SH) + (OFF_W+2)'(HEADER_BYTES) +
                     (OFF_W+2)'(xsz_q);
  assign merged    = xsz_q + SIZE_W'(HEADER_BYTES) + nbsz_q;

  logic fits_cur, better;
  assign fits_cur = {16'd0, rdata.size} >= need_q;
  assign better   = !found_q || (rdata.size < bsz_q);

  always_comb begin
    stat_o.act        = act_q;
    stat_o.ready      = ready_q;
    stat_o.addr_zero  = (addr_q == 32'd0);
    stat_o.req_zero   = (req_q == 32'd0);
    stat_o.addr_ok    = addr_ok;
    stat_o.rd_used    = rdata.used;
    stat_o.cur_valid  = link_ok(cur_q);
    stat_o.found      = found_q;
    stat_o.fits_x     = ({16'd0, xsz_q} >= need_q);
    stat_o.split_ok   = split_ok;
    stat_o.head_valid = link_ok(head_q);
    stat_o.p_valid    = link_ok(p_q);
    stat_o.n_valid    = link_ok(n_q);
    stat_o.rf_in      = right_off < (OFF_W+2)'(end_q);
    stat_o.out_free   = !out_valid_q || m_axis_tready;
  end

  // memory port per step
  always_comb begin
    we    = 1'b0;
    waddr = x_q;
    wdata = rdata;
    raddr = x_q;
    unique case (cmd_i.op)
      OP_INIT: begin
        we    = cfg_ok;
        waddr = '0;
        wdata = '{next: LINK_NULL, prev: LINK_NULL, used: 1'b0,
                  size: cfg_bytes_q - SIZE_W'(HEADER_BYTES)};
      end
      OP_T_RD:    raddr = cur_q[GIDX_W-1:0];
      OP_RD_BEST: raddr = best_q;
      OP_WR_USED: begin
        we         = 1'b1;
        waddr      = best_q;
        wdata.used = 1'b1;
      end
      OP_SP_RD:  raddr = sp_q;
      OP_SP_CHK: begin
        we         = split_ok;
        waddr      = sp_q;
        wdata.size = need_q[SIZE_W-1:0];
        wdata.used = 1'b1;
      end
      OP_PU_WR: begin
        we    = 1'b1;
        waddr = pu_q;
        wdata = '{next: head_q, prev: LINK_NULL, used: 1'b0, size: pusz_q};
      end
      OP_RD_HEAD:   raddr = head_q[GIDX_W-1:0];
      OP_HEAD_PREV: begin
        we         = 1'b1;
        waddr      = head_q[GIDX_W-1:0];
        wdata.prev = LINK_W'(pu_q);
      end
      OP_UL_RD: raddr = ul_q;
      OP_UL_P:  raddr = p_q[GIDX_W-1:0];
      OP_UL_PWR: begin
        we         = 1'b1;
        waddr      = p_q[GIDX_W-1:0];
        wdata.next = n_q;
      end
      OP_UL_N:  raddr = n_q[GIDX_W-1:0];
      OP_UL_NWR: begin
        we         = 1'b1;
        waddr      = n_q[GIDX_W-1:0];
        wdata.prev = p_q;
      end
      OP_AB_RF:   raddr = right_off[OFF_W-1:ALIGN_SH];
      OP_AB_MRGW: begin
        we         = 1'b1;
        waddr      = x_q;
        wdata.size = merged;
      end
      default: ;
    endcase
  end

  // configuration, list head and output handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_base_q  <= '0;
      cfg_bytes_q <= SIZE_W'(HEAP_MAX_BYTES);
      ready_q     <= 1'b0;
      head_q      <= LINK_NULL;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_HEAP_BASE) begin
          cfg_base_q <= cfg_wdata_i;
        end else if (cfg_idx_i == CFG_HEAP_BYTES) begin
          cfg_bytes_q <= cfg_wdata_i[SIZE_W-1:0];
        end
      end
      if (cmd_i.op == OP_INIT && cfg_ok) begin
        ready_q <= 1'b1;
        head_q  <= '0;
      end
      if (cmd_i.op == OP_SET_HEAD) begin
        head_q <= LINK_W'(pu_q);
      end
      if (cmd_i.op == OP_UL_P && !link_ok(p_q)) begin
        head_q <= link_ok(n_q) ? n_q : LINK_NULL;
      end
      if (cmd_i.op == OP_DONE && stat_o.out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers per step
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_in) begin
      act_q      <= act_e'(s_axis_tuser);
      addr_q     <= s_axis_tdata[31:0];
      req_q      <= s_axis_tdata[63:32];
      res_ok_q   <= 1'b0;
      res_copy_q <= 1'b0;
      res_addr_q <= '0;
      res_cb_q   <= '0;
    end
    unique case (cmd_i.op)
      OP_DISP: begin
        need_q  <= need_of(req_q);
        cur_q   <= head_q;
        found_q <= 1'b0;
        x_q     <= addr_idx;
        if (act_q != ACT_INIT && ready_q &&
            (((act_q == ACT_ALLOC || (act_q == ACT_REALLOC && addr_q == 32'd0)) &&
              req_q == 32'd0) || (act_q == ACT_FREE && addr_q == 32'd0))) begin
          res_ok_q <= 1'b1;
        end
      end
      OP_INIT: begin
        if (cfg_ok) begin
          lo_q     <= {1'b0, cfg_base_q} + 33'(HEADER_BYTES);
          end_q    <= cfg_bytes_q;
          res_ok_q <= 1'b1;
        end
      end
      OP_LK:     xsz_q <= rdata.size;
      OP_SET_OK: res_ok_q <= 1'b1;
      OP_SP_X:   sp_q <= x_q;
      OP_OK_X: begin
        res_ok_q   <= 1'b1;
        res_addr_q <= payload(lo_q, x_q);
      end
      OP_TK_INIT: begin
        cur_q   <= head_q;
        found_q <= 1'b0;
      end
      OP_RG_TOOK: begin
        if (found_q) begin
          res_ok_q   <= 1'b1;
          res_addr_q <= payload(lo_q, best_q);
          res_copy_q <= 1'b1;
          res_cb_q   <= xsz_q;
        end
      end
      OP_AL_END: begin
        if (found_q) begin
          res_ok_q   <= 1'b1;
          res_addr_q <= payload(lo_q, best_q);
        end
      end
      OP_T_CHK: begin
        if (fits_cur && better) begin
          best_q  <= cur_q[GIDX_W-1:0];
          bsz_q   <= rdata.size;
          found_q <= 1'b1;
        end
        cur_q <= rdata.next;
      end
      OP_T_END: sp_q <= best_q;
      OP_T_UL:  ul_q <= best_q;
      OP_SP_CHK: begin
        pu_q   <= cut_off[OFF_W-1:ALIGN_SH];
        pusz_q <= sp_rem - SIZE_W'(HEADER_BYTES);
      end
      OP_UL_GET: begin
        p_q <= rdata.prev;
        n_q <= rdata.next;
      end
      OP_REL: begin
        pu_q   <= x_q;
        pusz_q <= xsz_q;
      end
      OP_AB_RF: nb_q <= right_off[OFF_W-1:ALIGN_SH];
      OP_AB_CHK: begin
        nbsz_q <= rdata.size;
        ul_q   <= nb_q;
      end
      OP_AB_MRGW: xsz_q <= merged;
      OP_DONE: begin
        if (stat_o.out_free) begin
          out_ok_q   <= res_ok_q;
          out_addr_q <= res_addr_q;
          out_copy_q <= res_copy_q;
          out_cb_q   <= res_cb_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_cb_q, out_addr_q};
  assign m_axis_tuser  = {out_copy_q, out_ok_q};

endmodule

### rtl/bfa_ctrl.sv
module bfa_ctrl import bfa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_axis_tvalid,
  output logic  s_axis_tready,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE, ST_DISP, ST_INIT, ST_LK_RD, ST_LK_CHK, ST_FIN_OK, ST_RA_CHK, ST_RA_OK,
    ST_RG_TAKE, ST_RG_TOOK, ST_AL_END, ST_T_RD, ST_T_CHK, ST_T_END, ST_T_UL,
    ST_T_URD, ST_T_UWR, ST_SP_RD, ST_SP_CHK, ST_PU_WR, ST_PU_HRD, ST_PU_HWR,
    ST_PU_SETH, ST_UL_RD, ST_UL_GET, ST_UL_P, ST_UL_PWR, ST_UL_N, ST_UL_NWR,
    ST_REL, ST_AB_RF, ST_AB_CHK, ST_AB_MRG, ST_AB_MRGW, ST_RG_FIT, ST_DONE
  } state_e;

  state_e state_q;
  // return points of the shared sequences
  state_e ret_push_q, ret_split_q, ret_unlink_q, ret_take_q, ret_rel_q;
  logic   grow_q;

  // end of the neighbour merge loop
  state_e ab_exit;
  assign ab_exit = grow_q ? ST_RG_TAKE : ret_rel_q;

  assign s_axis_tready = (state_q == ST_IDLE);

  // step for the datapath
  always_comb begin
    cmd_o.take_in = (state_q == ST_IDLE) && s_axis_tvalid;
    unique case (state_q)
      ST_IDLE:    cmd_o.op = OP_IDLE;
      ST_DISP:    cmd_o.op = OP_DISP;
      ST_INIT:    cmd_o.op = OP_INIT;
      ST_LK_RD:   cmd_o.op = OP_RD_X;
      ST_LK_CHK:  cmd_o.op = OP_LK;
      ST_FIN_OK:  cmd_o.op = OP_SET_OK;
      ST_RA_CHK:  cmd_o.op = OP_SP_X;
      ST_RA_OK:   cmd_o.op = OP_OK_X;
      ST_RG_TAKE: cmd_o.op = OP_TK_INIT;
      ST_RG_TOOK: cmd_o.op = OP_RG_TOOK;
      ST_AL_END:  cmd_o.op = OP_AL_END;
      ST_T_RD:    cmd_o.op = OP_T_RD;
      ST_T_CHK:   cmd_o.op = OP_T_CHK;
      ST_T_END:   cmd_o.op = OP_T_END;
      ST_T_UL:    cmd_o.op = OP_T_UL;
      ST_T_URD:   cmd_o.op = OP_RD_BEST;
      ST_T_UWR:   cmd_o.op = OP_WR_USED;
      ST_SP_RD:   cmd_o.op = OP_SP_RD;
      ST_SP_CHK:  cmd_o.op = OP_SP_CHK;
      ST_PU_WR:   cmd_o.op = OP_PU_WR;
      ST_PU_HRD:  cmd_o.op = OP_RD_HEAD;
      ST_PU_HWR:  cmd_o.op = OP_HEAD_PREV;
      ST_PU_SETH: cmd_o.op = OP_SET_HEAD;
      ST_UL_RD:   cmd_o.op = OP_UL_RD;
      ST_UL_GET:  cmd_o.op = OP_UL_GET;
      ST_UL_P:    cmd_o.op = OP_UL_P;
      ST_UL_PWR:  cmd_o.op = OP_UL_PWR;
      ST_UL_N:    cmd_o.op = OP_UL_N;
      ST_UL_NWR:  cmd_o.op = OP_UL_NWR;
      ST_REL:     cmd_o.op = OP_REL;
      ST_AB_RF:   cmd_o.op = OP_AB_RF;
      ST_AB_CHK:  cmd_o.op = OP_AB_CHK;
      ST_AB_MRG:  cmd_o.op = OP_RD_X;
      ST_AB_MRGW: cmd_o.op = OP_AB_MRGW;
      ST_RG_FIT:  cmd_o.op = OP_SP_X;
      ST_DONE:    cmd_o.op = OP_DONE;
      default:    cmd_o.op = OP_NOP;
    endcase
  end

  // request sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ret_push_q   <= ST_IDLE;
      ret_split_q  <= ST_IDLE;
      ret_unlink_q <= ST_IDLE;
      ret_take_q   <= ST_IDLE;
      ret_rel_q    <= ST_IDLE;
      grow_q       <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: if (s_axis_tvalid) state_q <= ST_DISP;
        ST_DISP: begin
          priority if (stat_i.act == ACT_INIT) begin
            state_q <= ST_INIT;
          end else if (!stat_i.ready) begin
            state_q <= ST_DONE;
          end else if (stat_i.act == ACT_ALLOC ||
                       (stat_i.act == ACT_REALLOC && stat_i.addr_zero)) begin
            if (stat_i.req_zero) begin
              state_q <= ST_DONE;
            end else begin
              ret_take_q <= ST_AL_END;
              state_q    <= ST_T_RD;
            end
          end else if (stat_i.addr_zero || !stat_i.addr_ok) begin
            state_q <= ST_DONE;
          end else begin
            state_q <= ST_LK_RD;
          end
        end
        ST_INIT:   state_q <= ST_DONE;
        ST_LK_RD:  state_q <= ST_LK_CHK;
        ST_LK_CHK: begin
          priority if (!stat_i.rd_used) begin
            state_q <= ST_DONE;
          end else if (stat_i.act == ACT_FREE || stat_i.req_zero) begin
            ret_rel_q <= ST_FIN_OK;
            state_q   <= ST_REL;
          end else begin
            state_q <= ST_RA_CHK;
          end
        end
        ST_FIN_OK: state_q <= ST_DONE;
        ST_RA_CHK: begin
          if (stat_i.fits_x) begin
            ret_split_q <= ST_RA_OK;
            state_q     <= ST_SP_RD;
          end else begin
            grow_q  <= 1'b1;
            state_q <= ST_AB_RF;
          end
        end
        ST_RA_OK: state_q <= ST_DONE;
        ST_RG_TAKE: begin
          grow_q     <= 1'b0;
          ret_take_q <= ST_RG_TOOK;
          state_q    <= ST_T_RD;
        end
        ST_RG_TOOK: begin
          if (!stat_i.found) begin
            state_q <= ST_DONE;
          end else begin
            ret_rel_q <= ST_DONE;
            state_q   <= ST_REL;
          end
        end
        ST_AL_END: state_q <= ST_DONE;
        // best-fit walk of the free list
        ST_T_RD:  state_q <= stat_i.cur_valid ? ST_T_CHK : ST_T_END;
        ST_T_CHK: state_q <= ST_T_RD;
        ST_T_END: begin
          if (!stat_i.found) begin
            state_q <= ret_take_q;
          end else begin
            ret_split_q <= ST_T_UL;
            state_q     <= ST_SP_RD;
          end
        end
        ST_T_UL: begin
          ret_unlink_q <= ST_T_URD;
          state_q      <= ST_UL_RD;
        end
        ST_T_URD: state_q <= ST_T_UWR;
        ST_T_UWR: state_q <= ret_take_q;
        // split off the remainder
        ST_SP_RD:  state_q <= ST_SP_CHK;
        ST_SP_CHK: begin
          if (stat_i.split_ok) begin
            ret_push_q <= ret_split_q;
            state_q    <= ST_PU_WR;
          end else begin
            state_q <= ret_split_q;
          end
        end
        // push at list head
        ST_PU_WR:   state_q <= stat_i.head_valid ? ST_PU_HRD : ST_PU_SETH;
        ST_PU_HRD:  state_q <= ST_PU_HWR;
        ST_PU_HWR:  state_q <= ST_PU_SETH;
        ST_PU_SETH: state_q <= ret_push_q;
        // unlink from list
        ST_UL_RD:  state_q <= ST_UL_GET;
        ST_UL_GET: state_q <= ST_UL_P;
        ST_UL_P:   state_q <= stat_i.p_valid ? ST_UL_PWR : ST_UL_N;
        ST_UL_PWR: state_q <= ST_UL_N;
        ST_UL_N:   state_q <= stat_i.n_valid ? ST_UL_NWR : ret_unlink_q;
        ST_UL_NWR: state_q <= ret_unlink_q;
        // release and merge right neighbours
        ST_REL: begin
          grow_q     <= 1'b0;
          ret_push_q <= ST_AB_RF;
          state_q    <= ST_PU_WR;
        end
        ST_AB_RF:  state_q <= stat_i.rf_in ? ST_AB_CHK : ab_exit;
        ST_AB_CHK: begin
          if (stat_i.rd_used) begin
            state_q <= ab_exit;
          end else begin
            ret_unlink_q <= ST_AB_MRG;
            state_q      <= ST_UL_RD;
          end
        end
        ST_AB_MRG:  state_q <= ST_AB_MRGW;
        ST_AB_MRGW: state_q <= grow_q ? ST_RG_FIT : ST_AB_RF;
        ST_RG_FIT: begin
          if (stat_i.fits_x) begin
            ret_split_q <= ST_RA_OK;
            state_q     <= ST_SP_RD;
          end else begin
            state_q <= ST_AB_RF;
          end
        end
        ST_DONE: if (stat_i.out_free) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
